### src/decision_tree_terminal_node_core_defines.svh
// Assertion macros shared by the decision-tree terminal node core.
// Include by bare file name inside a module body; no dependencies.
`ifndef DECISION_TREE_TERMINAL_NODE_CORE_DEFINES_SVH
`define DECISION_TREE_TERMINAL_NODE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTTN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dttn implication check failed");

// next-cycle implication, disabled during reset
`define DTTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dttn next-cycle check failed");

`endif

### src/dttn_pkg.sv
// Types and constants of the decision-tree terminal node core.
// No dependencies; imported by dttn_walk and the top-level core.
`timescale 1ns / 1ps
`default_nettype none

package dttn_pkg;

  localparam int NODES     = 1024;
  localparam int VARIABLES = 64;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int VAR_AW    = $clog2(VARIABLES);

  localparam logic [1:0] REQ_NODE    = 2'd0;
  localparam logic [1:0] REQ_COUNT   = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;
  localparam logic [1:0] REQ_FIND    = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         node_index;
    logic               is_leaf;
    logic [5:0]         variable;
    logic signed [31:0] threshold;
    logic [63:0]        category_mask;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic [5:0]         category_count;
    logic signed [31:0] feature_value;
  } req_t;

  typedef struct packed {
    logic [9:0] terminal_node;
    logic       depth_exceeded;
    logic       bad_category;
  } rsp_t;

  typedef struct packed {
    logic               is_leaf;
    logic [5:0]         variable;
    logic signed [31:0] threshold;
    logic [63:0]        category_mask;
    logic [9:0]         right_child;
    logic [9:0]         left_child;
  } node_t;

  typedef struct packed {
    logic [5:0]         count;
    logic signed [31:0] feature;
  } var_t;

  typedef struct packed {
    node_t node;
    var_t  vars;
    logic  cnt_ok;
  } rd_t;

endpackage

`default_nettype wire

### src/dttn_ram.sv
// Generic simple dual-port RAM: one write port with bit enables, one
// registered read port. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dttn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wmask,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/dttn_walk.sv
// Tree walk sequencer: start node, per-level split decision, depth limit and
// result register. Depends on dttn_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module dttn_walk #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire dttn_pkg::req_t                 req,
  output logic                                req_stall,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output dttn_pkg::rsp_t                      rsp,
  input  wire dttn_pkg::rd_t                  rd,
  output logic [dttn_pkg::NODE_AW-1:0]        node_raddr
);
  import dttn_pkg::*;
  `include "decision_tree_terminal_node_core_defines.svh"

  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DECIDE = 3'b100
  } walk_st_t;

  walk_st_t          state, state_next;
  logic [NODE_AW-1:0] cur, cur_next;
  logic [DW-1:0]     steps, steps_next;
  logic              bad, bad_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic [5:0]  ncat;
  logic        categorical;
  logic        bad_now;
  logic        go_right;
  logic        at_limit;
  logic        finish;
  logic        out_free;

  always_comb begin
    ncat        = rd.cnt_ok ? rd.vars.count : 6'd1;
    categorical = ncat > 6'd1;
    bad_now     = categorical &&
                  ((rd.vars.feature < 32'sd1) ||
                   (rd.vars.feature > $signed({26'd0, ncat})));
    if (categorical) begin
      go_right = !bad_now && rd.node.category_mask[rd.vars.feature[5:0]];
    end else begin
      go_right = rd.vars.feature > rd.node.threshold;
    end
    at_limit = steps >= DW'(MAX_DEPTH);
    finish   = rd.node.is_leaf || at_limit;
    out_free = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    steps_next     = steps;
    bad_next       = bad;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req.req_type == REQ_FIND) begin
          cur_next   = req.node_index;
          steps_next = '0;
          bad_next   = 1'b0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (finish) begin
          if (out_free) begin
            rsp_valid_next          = 1'b1;
            rsp_next.terminal_node  = cur;
            rsp_next.depth_exceeded = !rd.node.is_leaf;
            rsp_next.bad_category   = bad;
            state_next              = ST_IDLE;
          end
        end else begin
          steps_next = steps + DW'(1);
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        bad_next   = bad || bad_now;
        cur_next   = go_right ? rd.node.right_child : rd.node.left_child;
        state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      steps     <= '0;
      bad       <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      steps     <= steps_next;
      bad       <= bad_next;
    end
    cur <= cur_next;
    rsp <= rsp_next;
  end

  assign req_stall  = state != ST_IDLE;
  assign node_raddr = cur_next;

  `DTTN_ASSERT_IMPLY(a_depth_bound, clk, rst, 1'b1, steps <= DW'(MAX_DEPTH))
  `DTTN_ASSERT_IMPLY(a_decide_after_check, clk, rst, state == ST_DECIDE,
                     $past(state) == ST_CHECK)
  `DTTN_ASSERT_IMPLY(a_rsp_from_check, clk, rst, $rose(rsp_valid),
                     $past(state) == ST_CHECK)
  `DTTN_ASSERT_NEXT(a_leaf_returns, clk, rst,
                    state == ST_CHECK && rd.node.is_leaf && out_free,
                    rsp_valid && rsp.terminal_node == $past(cur) &&
                    !rsp.depth_exceeded)

endmodule

`default_nettype wire

### src/decision_tree_terminal_node_core.sv
// Decision-tree terminal node core: request port, node table and variable
// memories, tree walk. Depends on dttn_pkg, dttn_ram and dttn_walk.
//
// Usage: one request channel (req_valid / req_stall / req) carries four
// kinds of beat: write node, write category count, write feature, find.
// A beat is taken when req_valid is high and req_stall low. Write beats
// produce nothing. A find beat walks the tree from node_index and
// returns one beat on the response channel (rsp_valid / rsp_stall / rsp)
// with the node reached (a leaf unless the depth limit stopped the walk),
// a depth flag and a bad-category flag. A find passes at most MAX_DEPTH
// internal nodes; each level costs one node memory read followed by one
// variable memory read. One find is in flight at a time; req_stall stays
// high until its result is registered, so no new find is taken before then.
// The result sits in an output register: while the receiver stalls it holds,
// and a new request is taken meanwhile; a second result waits in the walker.
// Reset clears the control state and marks every category count as
// continuous; node and feature entries must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module decision_tree_terminal_node_core #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire dttn_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output dttn_pkg::rsp_t      rsp
);
  import dttn_pkg::*;

  localparam int VAR_W = $bits(var_t);
  localparam int NODE_W = $bits(node_t);

  logic               accept;
  logic               node_we;
  logic               var_we;
  node_t              node_wdata;
  var_t               var_wdata;
  logic [VAR_W-1:0]   var_wmask;
  logic [NODE_AW-1:0] node_raddr;
  node_t              node_q;
  var_t               var_q;
  logic [VARIABLES-1:0] cnt_vld;
  logic               cnt_ok;
  rd_t                rd;

  assign accept  = req_valid && !req_stall;
  assign node_we = accept && req.req_type == REQ_NODE;
  assign var_we  = accept && (req.req_type == REQ_COUNT ||
                              req.req_type == REQ_FEATURE);

  always_comb begin
    node_wdata.is_leaf       = req.is_leaf;
    node_wdata.variable      = req.variable;
    node_wdata.threshold     = req.threshold;
    node_wdata.category_mask = req.category_mask;
    node_wdata.right_child   = req.right_child;
    node_wdata.left_child    = req.left_child;
    var_wdata.count          = req.category_count;
    var_wdata.feature        = req.feature_value;
    if (req.req_type == REQ_COUNT) begin
      var_wmask = {{6{1'b1}}, {(VAR_W - 6){1'b0}}};
    end else begin
      var_wmask = {{6{1'b0}}, {(VAR_W - 6){1'b1}}};
    end
  end

  dttn_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (req.node_index),
    .wmask ({NODE_W{1'b1}}),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_q)
  );

  dttn_ram #(
    .WIDTH (VAR_W),
    .DEPTH (VARIABLES)
  ) u_var_ram (
    .clk   (clk),
    .we    (var_we),
    .waddr (req.variable),
    .wmask (var_wmask),
    .wdata (var_wdata),
    .raddr (node_q.variable),
    .rdata (var_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (accept && req.req_type == REQ_COUNT) begin
      cnt_vld[req.variable] <= 1'b1;
    end
    cnt_ok <= cnt_vld[node_q.variable];
  end

  assign rd.node   = node_q;
  assign rd.vars   = var_q;
  assign rd.cnt_ok = cnt_ok;

  dttn_walk #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .rd         (rd),
    .node_raddr (node_raddr)
  );

endmodule

`default_nettype wire
